// File: hdl/knn_pkg.sv
`timescale 1ns / 1ps
// knn_pkg: request/response structs, mode, status and register codes
// for the k-nearest-neighbour classifier. No dependencies.
package knn_pkg;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_TRAIN  = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [2:0] STATUS_STORED     = 3'd0;
   localparam logic [2:0] STATUS_PREDICTION = 3'd1;
   localparam logic [2:0] STATUS_MISMATCH   = 3'd2;
   localparam logic [2:0] STATUS_FULL       = 3'd3;
   localparam logic [2:0] STATUS_EMPTY      = 3'd4;

   localparam logic CSR_NEIGHBOURS = 1'b0;
   localparam logic CSR_FEATURES   = 1'b1;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] feature_value;
      logic [1:0] class_label;
      logic       last_element;
   } knn_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [1:0] predicted_class;
   } knn_rsp_type;

   // chain control, common to every cell
   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } knn_cell_ctrl_type;

   // store write enables
   typedef struct packed {
      logic train_we;
      logic label_we;
      logic query_we;
   } knn_wr_type;

endpackage

// File: hdl/knn_dist.sv
`timescale 1ns / 1ps
// knn_dist: training/query stores and the squared-distance pipeline.
// Depends on knn_pkg.
module knn_dist #(
   parameter int MAX_TRAIN    = 1024,
   parameter int MAX_FEATURES = 16,
   parameter int FEATURE_BITS = 8,
   parameter int DIST_BITS    = 21
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  knn_pkg::knn_wr_type                      wr,
   input  logic [((MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1)-1:0]       wr_row,
   input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] wr_col,
   input  logic [FEATURE_BITS-1:0]                  wr_value,
   input  logic [1:0]                               wr_label,
   input  logic                                     scan_start,
   input  logic [$clog2(MAX_TRAIN+1)-1:0]           scan_rows,
   input  logic [4:0]                               scan_cols,
   output logic                                     scan_busy,
   output logic                                     ins_valid,
   output logic [DIST_BITS-1:0]                     ins_dist,
   output logic [1:0]                               ins_label
);

   localparam int TW  = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
   localparam int JW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int TCW = $clog2(MAX_TRAIN+1);
   localparam int FB  = FEATURE_BITS;

   logic [FB-1:0] feat_mem [MAX_TRAIN * (1 << JW)];
   logic [1:0]    label_mem [MAX_TRAIN];
   logic [FB-1:0] query_ff [MAX_FEATURES];

   logic           active_ff, active_in;
   logic [TCW-1:0] row_ff, row_in;
   logic [JW-1:0]  col_ff, col_in;
   logic           col_last;

   logic            s1_valid_ff, s1_last_ff;
   logic [FB-1:0]   s1_feat_ff, s1_query_ff;
   logic [1:0]      s1_label_ff;
   logic            s2_valid_ff, s2_last_ff;
   logic [2*FB-1:0] s2_sq_ff;
   logic [1:0]      s2_label_ff;
   logic [DIST_BITS-1:0] acc_ff, acc_sum;
   logic            out_valid_ff;
   logic [DIST_BITS-1:0] out_dist_ff;
   logic [1:0]      out_label_ff;
   logic [FB-1:0]   diff;

   // stores
   always_ff @(posedge clock) begin
      if (wr.train_we) begin
         feat_mem[{wr_row, wr_col}] <= wr_value;
      end
      if (wr.label_we) begin
         label_mem[wr_row] <= wr_label;
      end
      if (wr.query_we) begin
         query_ff[wr_col] <= wr_value;
      end
   end

   // row/column walk, one element a cycle
   always_comb begin
      col_last  = (7'(col_ff) + 7'd1) == 7'(scan_cols);
      active_in = active_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (scan_start) begin
         active_in = 1'b1;
         row_in    = '0;
         col_in    = '0;
      end else if (active_ff) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_ff + TCW'(1);
            if (row_ff + TCW'(1) == scan_rows) begin
               active_in = 1'b0;
            end
         end else begin
            col_in = col_ff + JW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
   end

   // stage 1: registered store reads
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= active_ff;
      end
      s1_last_ff  <= col_last;
      s1_feat_ff  <= feat_mem[{row_ff[TW-1:0], col_ff}];
      s1_query_ff <= query_ff[col_ff];
      s1_label_ff <= label_mem[row_ff[TW-1:0]];
   end

   // stage 2: absolute difference squared
   assign diff = (s1_feat_ff > s1_query_ff) ? s1_feat_ff - s1_query_ff
                                            : s1_query_ff - s1_feat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_last_ff  <= s1_last_ff;
      s2_sq_ff    <= (2*FB)'(diff) * (2*FB)'(diff);
      s2_label_ff <= s1_label_ff;
   end

   // stage 3: accumulate over the row
   assign acc_sum = acc_ff + DIST_BITS'(s2_sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         out_valid_ff <= s2_valid_ff & s2_last_ff;
         if (scan_start || (s2_valid_ff && s2_last_ff)) begin
            acc_ff <= '0;
         end else if (s2_valid_ff) begin
            acc_ff <= acc_sum;
         end
      end
      out_dist_ff  <= acc_sum;
      out_label_ff <= s2_label_ff;
   end

   assign scan_busy = active_ff | s1_valid_ff | s2_valid_ff | out_valid_ff;
   assign ins_valid = out_valid_ff;
   assign ins_dist  = out_dist_ff;
   assign ins_label = out_label_ff;

endmodule

// File: hdl/knn_cell.sv
`timescale 1ns / 1ps
// knn_cell: one slot of the sorted neighbour chain.
// Depends on knn_pkg.
module knn_cell #(
   parameter int DIST_BITS = 21
) (
   input  logic                       clock,
   input  logic                       reset,
   input  knn_pkg::knn_cell_ctrl_type ctrl,
   input  logic                       enable,
   input  logic [DIST_BITS-1:0]       ins_dist,
   input  logic [1:0]                 ins_label,
   input  logic                       left_take,
   input  logic                       left_valid,
   input  logic [DIST_BITS-1:0]       left_dist,
   input  logic [1:0]                 left_label,
   input  logic                       right_valid,
   input  logic [DIST_BITS-1:0]       right_dist,
   input  logic [1:0]                 right_label,
   output logic                       take,
   output logic                       valid,
   output logic [DIST_BITS-1:0]       cur_dist,
   output logic [1:0]                 label
);

   logic                 valid_ff;
   logic [DIST_BITS-1:0] dist_ff;
   logic [1:0]           label_ff;

   // strict compare: an equal distance lands behind, so lower index wins
   assign take = enable & ctrl.insert & (~valid_ff | (ins_dist < dist_ff));

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= right_valid;
         dist_ff  <= right_dist;
         label_ff <= right_label;
      end else if (take) begin
         if (left_take) begin
            valid_ff <= left_valid;
            dist_ff  <= left_dist;
            label_ff <= left_label;
         end else begin
            valid_ff <= 1'b1;
            dist_ff  <= ins_dist;
            label_ff <= ins_label;
         end
      end
   end

   assign valid    = valid_ff;
   assign cur_dist = dist_ff;
   assign label    = label_ff;

endmodule

// File: hdl/knn_classifier_unit.sv
`timescale 1ns / 1ps
// knn_classifier_unit: top level of the k-nearest-neighbour classifier.
// Depends on knn_pkg, knn_dist, knn_cell.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+------------------------------
//  request  | start, busy, req              | taken when start & !busy
//  response | rsp_valid, rsp                | one-cycle strobe, no backpressure
//  config   | csr_valid, csr_ready,         | written when csr_valid & csr_ready
//           | csr_index, csr_data           |
//
// Training and clear requests leave busy low; a training result appears on
// the cycle after the request's last element.
// A query's last element holds busy while the distance pipeline reads one
// stored feature per cycle from the training store, then while the chain
// shifts out one neighbour per cycle for voting. The response comes in the
// first cycle with busy low again.
// No clearing pass after reset; the stores need none.
// Responses cannot be stalled.
module knn_classifier_unit #(
   parameter int MAX_TRAIN    = 1024,
   parameter int MAX_FEATURES = 16,
   parameter int MAX_K        = 32,
   parameter int NUM_CLASSES  = 4,
   parameter int FEATURE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  knn_pkg::knn_req_type req,
   output logic                 rsp_valid,
   output knn_pkg::knn_rsp_type rsp,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [5:0]           csr_data
);

   localparam int TW   = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
   localparam int JW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int TCW  = $clog2(MAX_TRAIN+1);
   localparam int PW   = $clog2(MAX_FEATURES+1);
   localparam int KW   = $clog2(MAX_K+1);
   localparam int CW   = $clog2(NUM_CLASSES);
   localparam int DIST_BITS = 2*FEATURE_BITS + $clog2(MAX_FEATURES+1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_VOTE} state_type;

   // registers
   state_type      state_ff, state_in;
   logic [5:0]     nbr_ff;
   logic [4:0]     feat_cnt_ff;
   logic [TCW-1:0] train_cnt_ff, train_cnt_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic           len_err_ff, len_err_in;
   logic [KW-1:0]  fill_ff, fill_in;
   logic [KW-1:0]  vote_left_ff, vote_left_in;
   logic [KW-1:0]  best_ff, best_in;
   logic [CW-1:0]  winner_ff, winner_in;
   logic [KW-1:0]  votes_ff [NUM_CLASSES];
   logic [KW-1:0]  votes_in [NUM_CLASSES];
   logic           rsp_valid_ff, rsp_valid_in;
   knn_pkg::knn_rsp_type rsp_ff, rsp_in;

   logic           accept;
   logic [KW-1:0]  k_eff;
   logic [FEATURE_BITS-1:0] value;
   knn_pkg::knn_wr_type wr;
   logic           scan_start, scan_busy;
   logic           ins_valid;
   logic [DIST_BITS-1:0] ins_dist;
   logic [1:0]     ins_label;
   knn_pkg::knn_cell_ctrl_type ctrl;

   // chain wiring; the extra slot at the far end is always empty
   logic                 c_take  [MAX_K+1];
   logic                 c_valid [MAX_K+1];
   logic [DIST_BITS-1:0] c_dist  [MAX_K+1];
   logic [1:0]           c_label [MAX_K+1];

   logic [1:0]     head_red;
   logic [CW-1:0]  head_class;
   logic [KW-1:0]  head_votes;
   logic [PW-1:0]  count;
   logic           overflow;

   assign accept    = start & (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign value     = FEATURE_BITS'(req.feature_value);

   // k of zero acts as one, anything above the chain length as the length
   always_comb begin
      if (nbr_ff == 6'd0) begin
         k_eff = KW'(1);
      end else if (32'(nbr_ff) > MAX_K) begin
         k_eff = KW'(MAX_K);
      end else begin
         k_eff = KW'(nbr_ff);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nbr_ff      <= 6'd1;
         feat_cnt_ff <= 5'd6;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            knn_pkg::CSR_NEIGHBOURS: nbr_ff      <= csr_data;
            knn_pkg::CSR_FEATURES:   feat_cnt_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // store writes go out combinationally with the request
   assign overflow = (32'(pos_ff) >= MAX_FEATURES);
   assign count    = overflow ? pos_ff : pos_ff + PW'(1);

   always_comb begin
      wr = '0;
      if (accept && !overflow) begin
         wr.query_we = (req.mode == knn_pkg::MODE_QUERY);
         wr.train_we = (req.mode == knn_pkg::MODE_TRAIN) &&
                       (32'(train_cnt_ff) < MAX_TRAIN);
      end
      if (accept && req.last_element && (req.mode == knn_pkg::MODE_TRAIN) &&
          !(len_err_ff || overflow) && (8'(count) == 8'(feat_cnt_ff)) &&
          (32'(train_cnt_ff) < MAX_TRAIN)) begin
         wr.label_we = 1'b1;
      end
   end

   // head of the chain, label folded into the class range
   assign head_red   = (32'(c_label[0]) >= NUM_CLASSES) ?
                       2'(32'(c_label[0]) - NUM_CLASSES) : c_label[0];
   assign head_class = CW'(head_red);
   assign head_votes = votes_ff[head_class] + KW'(1);

   // control: element bookkeeping, scan launch and voting
   always_comb begin
      state_in     = state_ff;
      train_cnt_in = train_cnt_ff;
      pos_in       = pos_ff;
      len_err_in   = len_err_ff;
      fill_in      = fill_ff;
      vote_left_in = vote_left_ff;
      best_in      = best_ff;
      winner_in    = winner_ff;
      votes_in     = votes_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      scan_start   = 1'b0;
      ctrl         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.mode == knn_pkg::MODE_CLEAR) begin
                  train_cnt_in = '0;
                  pos_in       = '0;
                  len_err_in   = 1'b0;
               end else if (req.mode != knn_pkg::MODE_UNUSED) begin
                  pos_in     = count;
                  len_err_in = len_err_ff | overflow;
                  if (req.last_element) begin
                     pos_in       = '0;
                     len_err_in   = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                     if (len_err_ff || overflow ||
                         (8'(count) != 8'(feat_cnt_ff))) begin
                        rsp_in.status = knn_pkg::STATUS_MISMATCH;
                     end else if (req.mode == knn_pkg::MODE_TRAIN) begin
                        if (32'(train_cnt_ff) >= MAX_TRAIN) begin
                           rsp_in.status = knn_pkg::STATUS_FULL;
                        end else begin
                           rsp_in.status = knn_pkg::STATUS_STORED;
                           train_cnt_in  = train_cnt_ff + TCW'(1);
                        end
                     end else if (train_cnt_ff == '0) begin
                        rsp_in.status = knn_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        scan_start   = 1'b1;
                        ctrl.clear   = 1'b1;
                        fill_in      = '0;
                        state_in     = ST_SCAN;
                     end
                  end
               end
            end
         end
         ST_SCAN: begin
            ctrl.insert = ins_valid;
            if (ins_valid && (fill_ff < k_eff)) begin
               fill_in = fill_ff + KW'(1);
            end
            if (!scan_busy) begin
               vote_left_in = fill_ff;
               best_in      = '0;
               winner_in    = '0;
               for (int c = 0; c < NUM_CLASSES; c++) begin
                  votes_in[c] = '0;
               end
               state_in = ST_VOTE;
            end
         end
         ST_VOTE: begin
            if (vote_left_ff != '0) begin
               // nearest first; a class wins only on a strictly higher count
               ctrl.shift           = 1'b1;
               vote_left_in         = vote_left_ff - KW'(1);
               votes_in[head_class] = head_votes;
               if (head_votes > best_ff) begin
                  best_in   = head_votes;
                  winner_in = head_class;
               end
            end else begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = knn_pkg::STATUS_PREDICTION;
               rsp_in.predicted_class = 2'(winner_ff);
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         train_cnt_ff <= '0;
         pos_ff       <= '0;
         len_err_ff   <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         train_cnt_ff <= train_cnt_in;
         pos_ff       <= pos_in;
         len_err_ff   <= len_err_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vote_left_ff <= vote_left_in;
      best_ff      <= best_in;
      winner_ff    <= winner_in;
      votes_ff     <= votes_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   knn_dist #(
      .MAX_TRAIN    (MAX_TRAIN),
      .MAX_FEATURES (MAX_FEATURES),
      .FEATURE_BITS (FEATURE_BITS),
      .DIST_BITS    (DIST_BITS)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .wr_row     (train_cnt_ff[TW-1:0]),
      .wr_col     (pos_ff[JW-1:0]),
      .wr_value   (value),
      .wr_label   (req.class_label),
      .scan_start (scan_start),
      .scan_rows  (train_cnt_ff),
      .scan_cols  (feat_cnt_ff),
      .scan_busy  (scan_busy),
      .ins_valid  (ins_valid),
      .ins_dist   (ins_dist),
      .ins_label  (ins_label)
   );

   // sorted neighbour chain, nearest in cell 0
   assign c_valid[MAX_K] = 1'b0;
   assign c_dist[MAX_K]  = '0;
   assign c_label[MAX_K] = '0;
   assign c_take[MAX_K]  = 1'b0;

   for (genvar i = 0; i < MAX_K; i++) begin : g_cell
      logic                 lt, lv;
      logic [DIST_BITS-1:0] ld;
      logic [1:0]           ll;
      if (i == 0) begin : g_head
         assign lt = 1'b0;
         assign lv = 1'b0;
         assign ld = '0;
         assign ll = '0;
      end else begin : g_body
         assign lt = c_take[i-1];
         assign lv = c_valid[i-1];
         assign ld = c_dist[i-1];
         assign ll = c_label[i-1];
      end
      knn_cell #(
         .DIST_BITS (DIST_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .enable      (KW'(i) < k_eff),
         .ins_dist    (ins_dist),
         .ins_label   (ins_label),
         .left_take   (lt),
         .left_valid  (lv),
         .left_dist   (ld),
         .left_label  (ll),
         .right_valid (c_valid[i+1]),
         .right_dist  (c_dist[i+1]),
         .right_label (c_label[i+1]),
         .take        (c_take[i]),
         .valid       (c_valid[i]),
         .cur_dist    (c_dist[i]),
         .label       (c_label[i])
      );
   end

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (fill_ff <= k_eff))
      else $error("neighbour fill beyond k");

   a_pred_from_vote: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp.status == knn_pkg::STATUS_PREDICTION)) |->
      ($past(state_ff) == ST_VOTE))
      else $error("prediction without vote");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(accept) || ($past(state_ff) == ST_VOTE)))
      else $error("response without a request");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_VOTE) && (vote_left_ff != '0)) |-> c_valid[0])
      else $error("voting on an empty chain slot");

endmodule
